// ----- design/tdsch_pkg.sv -----
// Shared types and constants for the thread core dispatch scheduler.
// No dependencies; used by every module of the block.
package tdsch_pkg;

    // Table sizes, fixed by the widths of the request fields
    localparam int THREADS  = 16;
    localparam int CORES    = 4;
    localparam int TASKS    = 16;
    localparam int THREAD_W = 4;
    localparam int CORE_W   = 2;
    localparam int TASK_W   = 4;
    localparam int WAIT_W   = $clog2(THREADS + 1);

    // Request codes
    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_DONE   = 2'd1;
    localparam logic [1:0] MODE_JOIN   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;

    // Thread phases
    localparam logic [1:0] PH_FREE     = 2'd0;
    localparam logic [1:0] PH_RUNNABLE = 2'd1;
    localparam logic [1:0] PH_RUNNING  = 2'd2;
    localparam logic [1:0] PH_JOINABLE = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  task_id;
        logic [3:0]  thread_index;
        logic [1:0]  core_index;
        logic [31:0] entry_address;
        logic [31:0] entry_argument;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  thread_number;
        logic        start_valid;
        logic [1:0]  start_core;
        logic [31:0] start_entry;
        logic [31:0] start_arg;
        logic        wake_valid;
        logic [3:0]  wake_task;
        logic        must_sleep;
    } t_out_item;

    // Queue control and status between the engine and its queues
    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_sts;

endpackage

// ----- design/tdsch_fifo.sv -----
// Circular queue with a combinational head read, optionally loaded 0..DEPTH-1 at reset.
// Depends on tdsch_pkg for the control and status structs.
module tdsch_fifo #(
    parameter int   DEPTH   = 16,
    parameter int   WIDTH   = 4,
    parameter bit   PRELOAD = 1'b0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tdsch_pkg::t_fifo_ctl  i_ctl,
    input  logic [WIDTH-1:0]      i_data,
    output logic [WIDTH-1:0]      o_data,
    output tdsch_pkg::t_fifo_sts  o_sts
);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [IDX_W-1:0] r_head;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W:0]   w_sum;
    logic [IDX_W:0]   w_tail;
    logic             w_push;
    logic             w_pop;

    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == CNT_W'(DEPTH));
    assign o_data      = r_mem[r_head];

    // Drop a push into a full queue, ignore a pop from an empty one
    assign w_push = i_ctl.push && !o_sts.full;
    assign w_pop  = i_ctl.pop && !o_sts.empty;

    // Tail slot: head plus count, wrapped once
    assign w_sum  = {1'b0, r_head} + (IDX_W + 1)'(r_count);
    assign w_tail = (w_sum >= (IDX_W + 1)'(DEPTH)) ? w_sum - (IDX_W + 1)'(DEPTH) : w_sum;

    // Advance head and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= PRELOAD ? CNT_W'(DEPTH) : '0;
        end else begin
            if (w_pop) begin
                r_head <= (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            r_count <= r_count + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

    // Load the slots at reset when preloaded, write the tail on a push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n && PRELOAD) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_mem[i] <= WIDTH'(i);
            end
        end else if (w_push) begin
            r_mem[w_tail[IDX_W-1:0]] <= i_data;
        end
    end

endmodule

// ----- design/tdsch_engine.sv -----
// Scheduling decision and thread, core and join tables; computes one result per request.
// Depends on tdsch_pkg and tdsch_fifo (free, runnable and idle-core queues).
module tdsch_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  tdsch_pkg::t_in_item   i_req,
    output tdsch_pkg::t_out_item  o_res
);
    localparam int TW = tdsch_pkg::THREAD_W;
    localparam int CW = tdsch_pkg::CORE_W;
    localparam int KW = tdsch_pkg::TASK_W;
    localparam int WW = tdsch_pkg::WAIT_W;

    // Thread, core and task tables
    logic [1:0]    r_phase       [tdsch_pkg::THREADS];
    logic          r_armed       [tdsch_pkg::THREADS];
    logic [KW-1:0] r_owner       [tdsch_pkg::THREADS];
    logic [31:0]   r_entry       [tdsch_pkg::THREADS];
    logic [31:0]   r_arg         [tdsch_pkg::THREADS];
    logic          r_busy        [tdsch_pkg::CORES];
    logic [TW-1:0] r_core_thread [tdsch_pkg::CORES];
    logic [WW-1:0] r_join_wait   [tdsch_pkg::TASKS];

    // Queue hookup
    tdsch_pkg::t_fifo_ctl free_ctl, ready_ctl, idle_ctl;
    tdsch_pkg::t_fifo_sts free_sts, ready_sts, idle_sts;
    logic [TW-1:0] free_head, ready_head, free_wdata;
    logic [CW-1:0] idle_head;

    // Decode
    logic [TW-1:0] done_thr, own_thr;
    logic          done_armed;
    logic [KW-1:0] own;
    logic [WW-1:0] wait_cur, wait_dec;
    logic [1:0]    join_phase;
    logic          join_ok;
    logic          do_create, create_start, do_done, done_release, done_next;
    logic          do_join_free, do_join_arm;

    tdsch_fifo #(.DEPTH(tdsch_pkg::THREADS), .WIDTH(TW), .PRELOAD(1'b1)) u_free (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(free_ctl), .i_data(free_wdata),
        .o_data(free_head), .o_sts(free_sts)
    );

    tdsch_fifo #(.DEPTH(tdsch_pkg::THREADS), .WIDTH(TW), .PRELOAD(1'b0)) u_ready (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ready_ctl), .i_data(free_head),
        .o_data(ready_head), .o_sts(ready_sts)
    );

    tdsch_fifo #(.DEPTH(tdsch_pkg::CORES), .WIDTH(CW), .PRELOAD(1'b1)) u_idle (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(idle_ctl), .i_data(i_req.core_index),
        .o_data(idle_head), .o_sts(idle_sts)
    );

    // Look up the thread on the finishing core and the owner of that thread (done) or of the addressed thread
    assign done_thr   = r_core_thread[i_req.core_index];
    assign done_armed = r_armed[done_thr];
    assign own_thr    = (i_req.mode == tdsch_pkg::MODE_DONE) ? done_thr : i_req.thread_index;
    assign own        = r_owner[own_thr];
    assign wait_cur   = r_join_wait[own];
    assign wait_dec   = (wait_cur != '0) ? wait_cur - 1'b1 : wait_cur;
    assign join_phase = r_phase[i_req.thread_index];

    // Classify the request
    assign do_create    = (i_req.mode == tdsch_pkg::MODE_CREATE) && !free_sts.empty;
    assign create_start = do_create && !idle_sts.empty;
    assign do_done      = (i_req.mode == tdsch_pkg::MODE_DONE) && r_busy[i_req.core_index];
    assign done_release = do_done && done_armed;
    assign done_next    = do_done && !ready_sts.empty;
    assign join_ok      = (i_req.mode == tdsch_pkg::MODE_JOIN)
                          && (join_phase != tdsch_pkg::PH_FREE)
                          && !r_armed[i_req.thread_index];
    assign do_join_free = join_ok && (join_phase == tdsch_pkg::PH_JOINABLE);
    assign do_join_arm  = join_ok && (join_phase != tdsch_pkg::PH_JOINABLE);

    // Queue moves, taken only when the request advances
    assign free_ctl.pop   = i_go && do_create;
    assign free_ctl.push  = i_go && (done_release || do_join_free);
    assign free_wdata     = do_join_free ? i_req.thread_index : done_thr;
    assign ready_ctl.push = i_go && do_create && idle_sts.empty;
    assign ready_ctl.pop  = i_go && done_next;
    assign idle_ctl.pop   = i_go && create_start;
    assign idle_ctl.push  = i_go && do_done && ready_sts.empty;

    // Build the result
    always_comb begin
        o_res = '0;
        case (i_req.mode)
            tdsch_pkg::MODE_CREATE: begin
                if (free_sts.empty) begin
                    o_res.status = tdsch_pkg::ST_NO_FREE;
                end else begin
                    o_res.thread_number = free_head;
                    if (create_start) begin
                        o_res.start_valid = 1'b1;
                        o_res.start_core  = idle_head;
                        o_res.start_entry = i_req.entry_address;
                        o_res.start_arg   = i_req.entry_argument;
                    end
                end
            end
            tdsch_pkg::MODE_DONE: begin
                if (!do_done) begin
                    o_res.status = tdsch_pkg::ST_INVALID;
                end else begin
                    if (done_release && (wait_dec == '0)) begin
                        o_res.wake_valid = 1'b1;
                        o_res.wake_task  = own;
                    end
                    if (done_next) begin
                        o_res.start_valid = 1'b1;
                        o_res.start_core  = i_req.core_index;
                        o_res.start_entry = r_entry[ready_head];
                        o_res.start_arg   = r_arg[ready_head];
                    end
                end
            end
            tdsch_pkg::MODE_JOIN: begin
                if (!join_ok) begin
                    o_res.status = tdsch_pkg::ST_INVALID;
                end else begin
                    o_res.must_sleep = do_join_arm;
                end
            end
            default: begin
                o_res.status = tdsch_pkg::ST_INVALID;
            end
        endcase
    end

    // Update phases, join marks, core assignment and join counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tdsch_pkg::THREADS; i++) begin
                r_phase[i] <= tdsch_pkg::PH_FREE;
                r_armed[i] <= 1'b0;
            end
            for (int i = 0; i < tdsch_pkg::CORES; i++) begin
                r_busy[i]        <= 1'b0;
                r_core_thread[i] <= '0;
            end
            for (int i = 0; i < tdsch_pkg::TASKS; i++) begin
                r_join_wait[i] <= '0;
            end
        end else if (i_go) begin
            if (do_create) begin
                r_armed[free_head] <= 1'b0;
                r_phase[free_head] <= create_start ? tdsch_pkg::PH_RUNNING
                                                   : tdsch_pkg::PH_RUNNABLE;
                if (create_start) begin
                    r_busy[idle_head]        <= 1'b1;
                    r_core_thread[idle_head] <= free_head;
                end
            end
            if (do_done) begin
                r_phase[done_thr] <= done_armed ? tdsch_pkg::PH_FREE : tdsch_pkg::PH_JOINABLE;
                if (done_armed) begin
                    r_armed[done_thr] <= 1'b0;
                    r_join_wait[own]  <= wait_dec;
                end
                if (done_next) begin
                    r_core_thread[i_req.core_index] <= ready_head;
                    r_phase[ready_head]             <= tdsch_pkg::PH_RUNNING;
                end else begin
                    r_busy[i_req.core_index]        <= 1'b0;
                    r_core_thread[i_req.core_index] <= '0;
                end
            end
            if (do_join_free) begin
                r_phase[i_req.thread_index] <= tdsch_pkg::PH_FREE;
            end
            if (do_join_arm) begin
                r_armed[i_req.thread_index] <= 1'b1;
                r_join_wait[own]            <= wait_cur + 1'b1;
            end
        end
    end

    // Record owner, entry and argument of a created thread
    always_ff @(posedge i_clk) begin
        if (i_go && do_create) begin
            r_owner[free_head] <= i_req.task_id;
            r_entry[free_head] <= i_req.entry_address;
            r_arg[free_head]   <= i_req.entry_argument;
        end
    end

endmodule

// ----- design/thread_core_dispatch_scheduler.sv -----
// Top level of the thread core dispatch scheduler: request and result registers around the engine.
// Depends on tdsch_pkg and tdsch_engine.
//
//   channel   handshake                    payload
//   request   i_in_valid / o_in_ready      i_in_item  (tdsch_pkg::t_in_item)
//   result    o_out_valid / i_out_ready    o_out_item (tdsch_pkg::t_out_item)
//
// A request is registered on transfer and decided once the result register is free, when its
// result is written to the result register; a stalled result keeps it in the request register.
// One request per cycle is sustained while results are taken; the table read and write of the
// engine set that figure.
// Reset loads the free-thread and idle-core queues all at once; no clearing pass.
// A stalled result holds the result register; the request register still takes one more request.
module thread_core_dispatch_scheduler (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tdsch_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tdsch_pkg::t_out_item  o_out_item
);
    logic                 r_in_valid;
    tdsch_pkg::t_in_item  r_in_item;
    logic                 r_out_valid;
    tdsch_pkg::t_out_item r_out_item;
    tdsch_pkg::t_out_item w_res;
    logic                 w_advance;

    // Move the held request into the result register when that register frees up
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    tdsch_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(w_advance), .i_req(r_in_item), .o_res(w_res)
    );

    // Hold the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item <= w_res;
        end
    end

`ifndef SYNTHESIS
    // A decided request always shows up as a result in the next cycle
    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("decided request produced no result");

    // A held request that cannot advance keeps its contents
    a_request_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_item)))
        else $error("held request lost or changed");

    // A refused request starts nothing, wakes nothing and puts nobody to sleep
    a_refusal_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_item.status != tdsch_pkg::ST_OK)) |->
        (!r_out_item.start_valid && !r_out_item.wake_valid && !r_out_item.must_sleep))
        else $error("refused request carried an action");
`endif

endmodule

// ----- verif/tb.sv -----
// Self-checking bench for thread_core_dispatch_scheduler: a scripted opening, then random traffic.
// Depends on tdsch_pkg and the scheduler RTL; results are checked against typed rows or a local predictor.
module tb;
    import tdsch_pkg::*;

    localparam logic [1:0] MODE_UNKNOWN = 2'd3;
    localparam int PERIOD          = 10;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int RX_HOLD_CYCLES  = 400;
    // slowest correct run: one receiver hold of RX_HOLD_CYCLES plus the longest sender gap from idle_len
    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 8;
    localparam t_out_item NO_TYPED = '0;

    typedef struct {
        t_in_item  req;
        bit        typed;
        t_out_item res;
    } t_script_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  in_item   = '0;
    logic      o_out_valid;
    logic      out_ready = 1'b0;
    t_out_item o_out_item;

    // Expected results in transfer order
    t_out_item due_results[$];
    int        errors        = 0;
    int        results_seen  = 0;
    int        quiet_cycles  = 0;
    bit        sender_steady = 1'b0;
    bit        rx_hold_req   = 1'b0;
    bit        rx_hold_done  = 1'b0;

    // Predicted scheduler state
    logic [3:0]  free_q    [THREADS];
    int          free_head, free_cnt;
    logic [3:0]  ready_q   [THREADS];
    int          ready_head, ready_cnt;
    logic [1:0]  idle_q    [CORES];
    int          idle_head, idle_cnt;
    logic [1:0]  phase_of  [THREADS];
    bit          armed     [THREADS];
    logic [3:0]  owner_of  [THREADS];
    logic [31:0] entry_of  [THREADS];
    logic [31:0] arg_of    [THREADS];
    bit          busy      [CORES];
    logic [3:0]  thread_on [CORES];
    int          joins_due [TASKS];

    // Opening script: error cases first, then fill all cores, queue two threads,
    // arm joins, retire threads through the runnable FIFO and free them again
    t_script_row script [23] = '{
        '{'{MODE_UNKNOWN, 4'hF, 4'hF, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
          '{ST_INVALID, 4'd0, 1'b0, 2'd0, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0}},
        '{'{MODE_JOIN, 4'd0, 4'd15, 2'd0, 32'd0, 32'd0}, 1'b1,
          '{ST_INVALID, 4'd0, 1'b0, 2'd0, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0}},
        '{'{MODE_DONE, 4'd0, 4'd0, 2'd3, 32'd0, 32'd0}, 1'b1,
          '{ST_INVALID, 4'd0, 1'b0, 2'd0, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0}},
        '{'{MODE_CREATE, 4'd0, 4'd0, 2'd0, 32'd0, 32'd0}, 1'b1,
          '{ST_OK, 4'd0, 1'b1, 2'd0, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0}},
        '{'{MODE_CREATE, 4'd15, 4'd0, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
          '{ST_OK, 4'd1, 1'b1, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 4'd0, 1'b0}},
        '{'{MODE_CREATE, 4'd5, 4'd0, 2'd0, 32'h1000_0040, 32'hA5A5_5A5A}, 1'b1,
          '{ST_OK, 4'd2, 1'b1, 2'd2, 32'h1000_0040, 32'hA5A5_5A5A, 1'b0, 4'd0, 1'b0}},
        '{'{MODE_CREATE, 4'd5, 4'd0, 2'd0, 32'h1000_0080, 32'h0000_0003}, 1'b1,
          '{ST_OK, 4'd3, 1'b1, 2'd3, 32'h1000_0080, 32'h0000_0003, 1'b0, 4'd0, 1'b0}},
        '{'{MODE_CREATE, 4'd7, 4'd0, 2'd0, 32'h2000_0000, 32'hDEAD_BEEF}, 1'b1,
          '{ST_OK, 4'd4, 1'b0, 2'd0, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0}},
        '{'{MODE_CREATE, 4'd5, 4'd0, 2'd0, 32'h3000_0000, 32'h8000_0001}, 1'b1,
          '{ST_OK, 4'd5, 1'b0, 2'd0, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0}},
        '{'{MODE_JOIN, 4'd0, 4'd4, 2'd0, 32'd0, 32'd0}, 1'b1,
          '{ST_OK, 4'd0, 1'b0, 2'd0, 32'd0, 32'd0, 1'b0, 4'd0, 1'b1}},
        '{'{MODE_JOIN, 4'd0, 4'd4, 2'd0, 32'd0, 32'd0}, 1'b1,
          '{ST_INVALID, 4'd0, 1'b0, 2'd0, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0}},
        '{'{MODE_JOIN, 4'd0, 4'd2, 2'd0, 32'd0, 32'd0}, 1'b1,
          '{ST_OK, 4'd0, 1'b0, 2'd0, 32'd0, 32'd0, 1'b0, 4'd0, 1'b1}},
        '{'{MODE_JOIN, 4'd0, 4'd3, 2'd0, 32'd0, 32'd0}, 1'b1,
          '{ST_OK, 4'd0, 1'b0, 2'd0, 32'd0, 32'd0, 1'b0, 4'd0, 1'b1}},
        '{'{MODE_DONE, 4'd0, 4'd0, 2'd2, 32'd0, 32'd0}, 1'b0, NO_TYPED},
        '{'{MODE_DONE, 4'd0, 4'd0, 2'd3, 32'd0, 32'd0}, 1'b0, NO_TYPED},
        '{'{MODE_DONE, 4'd0, 4'd0, 2'd2, 32'd0, 32'd0}, 1'b0, NO_TYPED},
        '{'{MODE_DONE, 4'd0, 4'd0, 2'd0, 32'd0, 32'd0}, 1'b0, NO_TYPED},
        '{'{MODE_JOIN, 4'd0, 4'd0, 2'd0, 32'd0, 32'd0}, 1'b0, NO_TYPED},
        '{'{MODE_JOIN, 4'd0, 4'd0, 2'd0, 32'd0, 32'd0}, 1'b1,
          '{ST_INVALID, 4'd0, 1'b0, 2'd0, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0}},
        '{'{MODE_DONE, 4'd0, 4'd0, 2'd0, 32'd0, 32'd0}, 1'b1,
          '{ST_INVALID, 4'd0, 1'b0, 2'd0, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0}},
        '{'{MODE_DONE, 4'd0, 4'd0, 2'd1, 32'd0, 32'd0}, 1'b0, NO_TYPED},
        '{'{MODE_CREATE, 4'd9, 4'd0, 2'd0, 32'h0000_0001, 32'h7FFF_FFFF}, 1'b0, NO_TYPED},
        '{'{MODE_JOIN, 4'd0, 4'd1, 2'd0, 32'd0, 32'd0}, 1'b0, NO_TYPED}
    };

    thread_core_dispatch_scheduler u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    always #(PERIOD / 2) clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Put a thread on a core and report the start
    function automatic void launch(input logic [1:0] core, input logic [3:0] thr,
                                   inout t_out_item res);
        busy[core]      = 1'b1;
        thread_on[core] = thr;
        phase_of[thr]   = PH_RUNNING;
        res.start_valid = 1'b1;
        res.start_core  = core;
        res.start_entry = entry_of[thr];
        res.start_arg   = arg_of[thr];
    endfunction

    // Return a thread to the tail of the free FIFO
    function automatic void release_thread(input logic [3:0] thr);
        phase_of[thr] = PH_FREE;
        armed[thr]    = 1'b0;
        if (free_cnt < THREADS) begin
            free_q[(free_head + free_cnt) % THREADS] = thr;
            free_cnt++;
        end
    endfunction

    // Advance the predicted state by one request and return its result
    function automatic t_out_item dispatch_step(input t_in_item req);
        t_out_item  res;
        logic [3:0] thr;
        logic [1:0] core;
        logic [3:0] own;
        res = '0;
        case (req.mode)
            MODE_CREATE: begin
                if (free_cnt == 0) begin
                    res.status = ST_NO_FREE;
                end else begin
                    thr = free_q[free_head];
                    free_head = (free_head + 1) % THREADS;
                    free_cnt--;
                    owner_of[thr] = req.task_id;
                    entry_of[thr] = req.entry_address;
                    arg_of[thr]   = req.entry_argument;
                    armed[thr]    = 1'b0;
                    res.thread_number = thr;
                    if (idle_cnt == 0) begin
                        phase_of[thr] = PH_RUNNABLE;
                        ready_q[(ready_head + ready_cnt) % THREADS] = thr;
                        ready_cnt++;
                    end else begin
                        core = idle_q[idle_head];
                        idle_head = (idle_head + 1) % CORES;
                        idle_cnt--;
                        launch(core, thr, res);
                    end
                end
            end
            MODE_DONE: begin
                core = req.core_index;
                if (!busy[core]) begin
                    res.status = ST_INVALID;
                end else begin
                    thr = thread_on[core];
                    if (armed[thr]) begin
                        own = owner_of[thr];
                        if (joins_due[own] > 0) joins_due[own]--;
                        if (joins_due[own] == 0) begin
                            res.wake_valid = 1'b1;
                            res.wake_task  = own;
                        end
                        release_thread(thr);
                    end else begin
                        phase_of[thr] = PH_JOINABLE;
                    end
                    if (ready_cnt == 0) begin
                        busy[core]      = 1'b0;
                        thread_on[core] = '0;
                        if (idle_cnt < CORES) begin
                            idle_q[(idle_head + idle_cnt) % CORES] = core;
                            idle_cnt++;
                        end
                    end else begin
                        thr = ready_q[ready_head];
                        ready_head = (ready_head + 1) % THREADS;
                        ready_cnt--;
                        launch(core, thr, res);
                    end
                end
            end
            MODE_JOIN: begin
                thr = req.thread_index;
                if (phase_of[thr] == PH_FREE || armed[thr]) begin
                    res.status = ST_INVALID;
                end else if (phase_of[thr] == PH_JOINABLE) begin
                    release_thread(thr);
                end else begin
                    armed[thr] = 1'b1;
                    joins_due[owner_of[thr]]++;
                    res.must_sleep = 1'b1;
                end
            end
            default: begin
                res.status = ST_INVALID;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("result %0d: %s is %h, expected %h", results_seen, field, got, want);
        errors++;
    endtask

    task automatic check_result(input t_out_item got, input t_out_item want);
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.thread_number !== want.thread_number)
            report_mismatch("thread_number", 32'(got.thread_number), 32'(want.thread_number));
        if (got.start_valid !== want.start_valid)
            report_mismatch("start_valid", 32'(got.start_valid), 32'(want.start_valid));
        if (got.start_core !== want.start_core)
            report_mismatch("start_core", 32'(got.start_core), 32'(want.start_core));
        if (got.start_entry !== want.start_entry)
            report_mismatch("start_entry", got.start_entry, want.start_entry);
        if (got.start_arg !== want.start_arg)
            report_mismatch("start_arg", got.start_arg, want.start_arg);
        if (got.wake_valid !== want.wake_valid)
            report_mismatch("wake_valid", 32'(got.wake_valid), 32'(want.wake_valid));
        if (got.wake_task !== want.wake_task)
            report_mismatch("wake_task", 32'(got.wake_task), 32'(want.wake_task));
        if (got.must_sleep !== want.must_sleep)
            report_mismatch("must_sleep", 32'(got.must_sleep), 32'(want.must_sleep));
    endtask

    // Offer one request, hold it until transfer, then record its expected result
    task automatic send_req(input t_in_item req, input bit typed, input t_out_item typed_res);
        t_out_item res;
        int        gap;
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (!o_in_ready);
        res = dispatch_step(req);
        due_results.push_back(typed ? typed_res : res);
        gap = sender_steady ? 0 : idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every expected result has come out
    task automatic settle();
        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Check results on the falling edge ahead of the rising edge that transfers them
    always @(negedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result, status", 32'(o_out_item.status), 32'd0);
            end else begin
                check_result(o_out_item, due_results.pop_front());
            end
            results_seen++;
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: ready runs with random gaps, plus one long hold-off on request
    initial begin : rx_side
        int run;
        int gap;
        out_ready <= 1'b1;
        forever begin
            run = $urandom_range(1, 40);
            repeat (run) @(posedge clk);
            if (rx_hold_req && !rx_hold_done) begin
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_done = 1'b1;
                out_ready <= 1'b1;
            end else begin
                gap = idle_len();
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        t_in_item req;
        int       ph;
        int       n;
        int       i;
        int       roll;
        int       create_pct;
        int       done_pct;
        int       cand[$];

        // Predicted state after reset
        for (i = 0; i < THREADS; i++) begin
            free_q[i]   = 4'(i);
            ready_q[i]  = '0;
            phase_of[i] = PH_FREE;
            armed[i]    = 1'b0;
            owner_of[i] = '0;
            entry_of[i] = '0;
            arg_of[i]   = '0;
        end
        for (i = 0; i < CORES; i++) begin
            idle_q[i]    = 2'(i);
            busy[i]      = 1'b0;
            thread_on[i] = '0;
        end
        for (i = 0; i < TASKS; i++) joins_due[i] = 0;
        free_head  = 0;
        free_cnt   = THREADS;
        ready_head = 0;
        ready_cnt  = 0;
        idle_head  = 0;
        idle_cnt   = CORES;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[k]) send_req(script[k].req, script[k].typed, script[k].res);
        settle();

        for (ph = 0; ph < PHASES; ph++) begin
            sender_steady = (ph % 2 == 1);
            if (ph == 2) rx_hold_req = 1'b1;
            // balanced, create-heavy, or retire-heavy traffic
            case (ph % 3)
                0: begin create_pct = 40; done_pct = 35; end
                1: begin create_pct = 70; done_pct = 15; end
                default: begin create_pct = 20; done_pct = 45; end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                req.mode           = 2'($urandom_range(0, 2));
                req.task_id        = 4'($urandom_range(0, TASKS - 1));
                req.thread_index   = 4'($urandom_range(0, THREADS - 1));
                req.core_index     = 2'($urandom_range(0, CORES - 1));
                req.entry_address  = $urandom;
                req.entry_argument = $urandom;
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    req.mode = MODE_UNKNOWN;
                end else if (roll >= 12) begin
                    // aim at a busy core or a thread that is neither free nor armed to keep requests well formed
                    roll = $urandom_range(0, 99);
                    cand.delete();
                    if (roll < create_pct) begin
                        req.mode = MODE_CREATE;
                    end else if (roll < create_pct + done_pct) begin
                        for (i = 0; i < CORES; i++) if (busy[i]) cand.push_back(i);
                        if (cand.size() == 0) begin
                            req.mode = MODE_CREATE;
                        end else begin
                            req.mode       = MODE_DONE;
                            req.core_index = 2'(cand[$urandom_range(0, cand.size() - 1)]);
                        end
                    end else begin
                        for (i = 0; i < THREADS; i++)
                            if (phase_of[i] != PH_FREE && !armed[i]) cand.push_back(i);
                        if (cand.size() == 0) begin
                            req.mode = MODE_CREATE;
                        end else begin
                            req.mode         = MODE_JOIN;
                            req.thread_index = 4'(cand[$urandom_range(0, cand.size() - 1)]);
                        end
                    end
                end
                send_req(req, 1'b0, NO_TYPED);
            end
            settle();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
